[sv/signed_int_to_radix_ascii_core_assert.svh]
// Assertion macros for the signed integer to radix text core.
`ifndef SIGNED_INT_TO_RADIX_ASCII_CORE_ASSERT_SVH
`define SIGNED_INT_TO_RADIX_ASCII_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SIRAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SIRAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SIRAC_ASSERT_NOW(lbl, ante, cons, msg)
`define SIRAC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[sv/sirac_pkg.sv]
// Types, constants and the digit encoder for the radix text core.
package sirac_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_EMIT
    } sirac_state_t;

    localparam logic [5:0] RADIX_MIN     = 6'd2;
    localparam logic [5:0] RADIX_MAX     = 6'd36;
    localparam logic [5:0] DIGIT_LIMIT   = 6'd9;
    localparam logic [5:0] LETTER_OFFSET = 6'd10;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_A        = 8'h61;
    localparam logic [7:0] CHAR_MINUS    = 8'h2d;

    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [7:0] c;
        if (d > DIGIT_LIMIT)
        begin
            c = CHAR_A + {2'b00, 6'(d - LETTER_OFFSET)};
        end
        else
        begin
            c = CHAR_ZERO + {2'b00, d};
        end
        return c;
    endfunction

endpackage

[sv/sirac_in_if.sv]
// Input channel: one signed value and its radix per item.
interface sirac_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic        [5:0]            radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

[sv/sirac_out_if.sv]
// Output channel: one ASCII character per item, with an end-of-number flag.
interface sirac_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

[sv/signed_int_to_radix_ascii_core.sv]
// Signed integer to radix text converter, one character per output item.
//
// Usage: din takes a signed VALUE_BITS-wide value and a radix (2 to 36, codes
// below 2 act as 2 and codes above 36 act as 36). dout returns the text most
// significant character first: a leading '-' for negative values, digits
// '0'..'9' and 'a'..'z', with last set on the final character.
// A zero value gives the single character '0'.
// The block takes one value at a time; din.ready is high only while it is idle.
// Each digit comes from a shared one-bit restoring divider,
// which produces digits least significant first into a small digit memory.
// After division, a negative value first emits the minus sign; each character
// is then read out as a memory read followed by presenting it on dout.
// A stalled receiver simply holds the current character; nothing is lost.
// Reset returns the block to idle and abandons any value in progress.
module signed_int_to_radix_ascii_core
    import sirac_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    sirac_in_if.sink     din,
    sirac_out_if.source  dout
);

    localparam int AW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam logic [AW-1:0] BIT_LAST = AW'(VALUE_BITS - 1);
    localparam logic [CW-1:0] ONE_DIGIT = CW'(1);

    sirac_state_t state_reg, state_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [5:0] rem_reg, rem_next;
    logic [5:0] radix_reg, radix_next;
    logic neg_reg, neg_next;
    logic [AW-1:0] bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0] ndig_reg, ndig_next;
    logic [5:0] rd_data_reg;

    logic [5:0] digit_mem [VALUE_BITS];

    logic [VALUE_BITS-1:0] in_raw;
    logic [VALUE_BITS-1:0] in_mag;
    logic [5:0] in_radix;
    logic [6:0] rem_shift;
    logic div_ge;
    logic [5:0] div_rem;
    logic [VALUE_BITS-1:0] div_mag;
    logic mem_we;
    logic [CW-1:0] ndig_m1;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // Input conditioning: magnitude as unsigned, radix clamped into range.
    always_comb
    begin
        in_raw = din.value;
        in_mag = in_raw[VALUE_BITS-1] ? (~in_raw + 1'b1) : in_raw;
        if (din.radix < RADIX_MIN)
        begin
            in_radix = RADIX_MIN;
        end
        else if (din.radix > RADIX_MAX)
        begin
            in_radix = RADIX_MAX;
        end
        else
        begin
            in_radix = din.radix;
        end
    end

    // One restoring division step; quotient bits shift into the magnitude.
    always_comb
    begin
        rem_shift = {rem_reg, mag_reg[VALUE_BITS-1]};
        div_ge    = rem_shift >= {1'b0, radix_reg};
        div_rem   = div_ge ? 6'(rem_shift - {1'b0, radix_reg}) : rem_shift[5:0];
        div_mag   = {mag_reg[VALUE_BITS-2:0], div_ge};
    end

    assign ndig_m1 = ndig_reg - ONE_DIGIT;
    assign wr_addr = ndig_reg[AW-1:0];
    assign rd_addr = ndig_m1[AW-1:0];

    // Next state and datapath.
    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        rem_next     = rem_reg;
        radix_next   = radix_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        ndig_next    = ndig_reg;
        mem_we       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    mag_next     = in_mag;
                    neg_next     = in_raw[VALUE_BITS-1];
                    radix_next   = in_radix;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    ndig_next    = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                mag_next     = div_mag;
                rem_next     = div_rem;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_LAST)
                begin
                    // Digit complete: the remainder is stored, the quotient goes on.
                    mem_we       = 1'b1;
                    ndig_next    = ndig_reg + ONE_DIGIT;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    if (div_mag == '0)
                    begin
                        state_next = neg_reg ? ST_SIGN : ST_READ;
                    end
                end
            end
            ST_SIGN:
            begin
                if (dout.ready)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (dout.ready)
                begin
                    ndig_next  = ndig_m1;
                    state_next = (ndig_reg == ONE_DIGIT) ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        din.ready      = 1'b0;
        dout.valid     = 1'b0;
        dout.character = digit_char(rd_data_reg);
        dout.last      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                din.ready = 1'b1;
            end
            ST_SIGN:
            begin
                dout.valid     = 1'b1;
                dout.character = CHAR_MINUS;
            end
            ST_EMIT:
            begin
                dout.valid = 1'b1;
                dout.last  = (ndig_reg == ONE_DIGIT);
            end
            default:
            begin
                din.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            ndig_reg    <= '0;
            neg_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            ndig_reg    <= ndig_next;
            neg_reg     <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
    end

    // Digit memory: written as digits are found, read back in reverse order.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[wr_addr] <= div_rem;
        end
        rd_data_reg <= digit_mem[rd_addr];
    end

`include "signed_int_to_radix_ascii_core_assert.svh"

    `SIRAC_ASSERT_NOW(a_busy_when_emitting, dout.valid, !din.ready, "output while accepting input")
    `SIRAC_ASSERT_NOW(a_rem_below_radix, state_reg == ST_DIV, rem_reg < radix_reg, "remainder not below radix")
    `SIRAC_ASSERT_NOW(a_digits_in_range, state_reg == ST_EMIT, (ndig_reg != '0) && (ndig_reg <= CW'(VALUE_BITS)), "digit count out of range")
    `SIRAC_ASSERT_NEXT(a_idle_after_last, dout.valid && dout.ready && dout.last, din.ready, "not idle after last character")

endmodule
